>>> rtl/ptlt_pkg.sv
// Package for the peer table with loss tracking: sizes, item and result types.
// No dependencies.
`default_nettype none
package ptlt_pkg;
  localparam int PEER_SLOTS = 4;
  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0] HB_RESET = 8'd0;
  localparam logic [0:0] CFG_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_HB = 1'b1;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_RAW = 2'd2;
  localparam logic [1:0] MODE_REPORT = 2'd3;

  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [7:0]  frame_msg_id;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_sys_id;
    logic [7:0]  frame_comp_id;
  } item_t;

  typedef struct packed {
    logic [1:0] slot_status;
    logic [3:0] slot_index;
    logic [7:0] frame_loss;
    logic       any_peer_active;
    logic       heard_flag;
    logic       all_timed_out;
    logic [7:0] owner_sys_id;
    logic [7:0] owner_comp_id;
    logic [6:0] loss_percent;
  } result_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    item_t             item;
    logic              hit;
    logic              free;
    logic [SLOT_W-1:0] slot;
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/ptlt_if.sv
// Valid/ready channel interfaces, each carrying one packed payload.
// Depends on ptlt_pkg; the payloads are its item_t and result_t types.
`default_nettype none
interface ptlt_item_if;
  import ptlt_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptlt_result_if;
  import ptlt_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ptlt_queue.sv
// Two-entry queue of classified commands between front and back parts.
// Depends on ptlt_pkg.
`default_nettype none
module ptlt_queue
  import ptlt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      pop_data
);
  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/ptlt_divider.sv
// Serial restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on nothing.
`default_nettype none
module ptlt_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[63]};
  assign diff = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        quo <= dividend;
        rem <= 33'd0;
        dvs <= divisor;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/ptlt_back.sv
// Back part: holds the peer table, executes commands and builds results.
// Depends on ptlt_pkg, ptlt_result_if and ptlt_divider.
`default_nettype none
module ptlt_back
  import ptlt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] silence_timeout_ms,
  input  wire logic [7:0]  heartbeat_msg_id,
  input  wire logic        cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic [PEER_SLOTS-1:0] active_out,
  output logic [31:0]      addr_out [PEER_SLOTS],
  output logic [15:0]      port_out [PEER_SLOTS],
  ptlt_result_if.source    res
);
  typedef enum logic [2:0] {S_IDLE, S_SUM, S_MUL, S_DIV, S_OUT} state_t;

  state_t            state;
  logic [PEER_SLOTS-1:0] active;
  logic [31:0]       last_seen [PEER_SLOTS];
  logic [PEER_SLOTS-1:0] heard;
  logic [7:0]        seq_exp [PEER_SLOTS];
  logic [31:0]       rx_cnt [PEER_SLOTS];
  logic [31:0]       lost_cnt [PEER_SLOTS];
  logic              global_heard;
  logic [7:0]        owner_system, owner_component;
  logic [31:0]       rx_sum, lost_sum;
  logic [SLOT_W-1:0] sum_idx;
  logic [63:0]       product;
  logic              div_start, div_done;
  logic [63:0]       quotient;
  result_t           result;

  cmd_t              c;
  logic [SLOT_W-1:0] s;
  logic [PEER_SLOTS-1:0] expire;
  logic [PEER_SLOTS-1:0] act_next;
  logic [7:0]        loss;
  logic [31:0]       addr_q [PEER_SLOTS];
  logic [15:0]       port_q [PEER_SLOTS];

  assign active_out = active;
  assign addr_out = addr_q;
  assign port_out = port_q;

  assign c = cmd;
  assign s = cmd.slot;
  assign loss = cmd.item.frame_seq - seq_exp[s];
  assign cmd_pop = (state == S_IDLE) && cmd_valid && !res.valid;
  assign res.data = result;

  always_comb begin
    for (int i = 0; i < PEER_SLOTS; i++) begin
      expire[i] = active[i] &&
        ((c.item.now_ms - last_seen[i]) > {16'd0, silence_timeout_ms});
    end
    act_next = active & ~expire;
  end

  ptlt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (rx_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      global_heard <= 1'b0;
      owner_system <= 8'd0;
      owner_component <= 8'd0;
      res.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            result.slot_status <= ST_NONE;
            result.slot_index <= 4'd0;
            result.frame_loss <= 8'd0;
            result.all_timed_out <= 1'b0;
            result.loss_percent <= 7'd0;
            result.owner_sys_id <= owner_system;
            result.owner_comp_id <= owner_component;
            result.heard_flag <= global_heard;
            result.any_peer_active <= |active;
            case (c.item.mode)
              MODE_TICK: begin
                active <= act_next;
                result.any_peer_active <= |act_next;
                if (global_heard && !(|act_next)) begin
                  global_heard <= 1'b0;
                  result.heard_flag <= 1'b0;
                  result.all_timed_out <= 1'b1;
                end
                state <= S_OUT;
              end
              MODE_FRAME, MODE_RAW: begin
                state <= S_OUT;
                if (!c.hit && !c.free) begin
                  result.slot_status <= ST_FULL;
                end else begin
                  result.slot_index <= 4'(s);
                  result.slot_status <= c.hit ? ST_EXISTING : ST_ADDED;
                  result.any_peer_active <= 1'b1;
                  last_seen[s] <= c.item.now_ms;
                  if (!c.hit) begin
                    active[s] <= 1'b1;
                    addr_q[s] <= c.item.peer_addr;
                    port_q[s] <= c.item.peer_port;
                    heard[s] <= 1'b0;
                    seq_exp[s] <= 8'd0;
                    rx_cnt[s] <= 32'd0;
                    lost_cnt[s] <= 32'd0;
                  end
                  if (c.item.mode == MODE_FRAME) begin
                    rx_cnt[s] <= (c.hit ? rx_cnt[s] : 32'd0) + 32'd1;
                    if (!c.hit || !heard[s]) begin
                      if (c.item.frame_msg_id == heartbeat_msg_id) begin
                        heard[s] <= 1'b1;
                        seq_exp[s] <= c.item.frame_seq + 8'd1;
                        if (!global_heard) begin
                          global_heard <= 1'b1;
                          owner_system <= c.item.frame_sys_id;
                          owner_component <= c.item.frame_comp_id;
                          result.heard_flag <= 1'b1;
                          result.owner_sys_id <= c.item.frame_sys_id;
                          result.owner_comp_id <= c.item.frame_comp_id;
                        end
                      end
                    end else begin
                      result.frame_loss <= loss;
                      seq_exp[s] <= c.item.frame_seq + 8'd1;
                      lost_cnt[s] <= lost_cnt[s] + {24'd0, loss};
                    end
                  end
                end
              end
              default: begin
                rx_sum <= 32'd0;
                lost_sum <= 32'd0;
                sum_idx <= '0;
                state <= S_SUM;
              end
            endcase
          end
        end
        // Accumulate one slot per cycle.
        S_SUM: begin
          if (active[sum_idx]) begin
            rx_sum <= rx_sum + rx_cnt[sum_idx];
            lost_sum <= lost_sum + lost_cnt[sum_idx];
          end
          if (32'(sum_idx) == PEER_SLOTS - 1) state <= S_MUL;
          else sum_idx <= sum_idx + 1'b1;
        end
        S_MUL: begin
          product <= {32'd0, lost_sum} * 64'd100;
          if (rx_sum == 32'd0) begin
            result.loss_percent <= 7'd100;
            state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            result.loss_percent <= (quotient > 64'd100) ? 7'd100 : quotient[6:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          res.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/ptlt_front.sv
// Front part: accepts items and classifies the peer key against the table.
// Depends on ptlt_pkg and ptlt_item_if.
`default_nettype none
module ptlt_front
  import ptlt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  ptlt_item_if.sink             in_ch,
  input  wire logic             q_full,
  input  wire logic             q_empty,
  input  wire logic             back_idle,
  input  wire logic [PEER_SLOTS-1:0] active,
  input  wire logic [31:0]      addr [PEER_SLOTS],
  input  wire logic [15:0]      port [PEER_SLOTS],
  output logic                  push,
  output cmd_t                  push_data
);
  // Classification reads the table, so an item enters only once earlier ones
  // have finished updating it.
  logic busy;
  logic hit, free;
  logic [SLOT_W-1:0] hs, fs;

  assign in_ch.ready = !busy && q_empty && back_idle && !q_full;
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hs = '0;
    fs = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (active[i] && addr[i] == in_ch.data.peer_addr && port[i] == in_ch.data.peer_port) begin
        hit = 1'b1;
        hs = SLOT_W'(i);
      end
      if (!active[i]) begin
        free = 1'b1;
        fs = SLOT_W'(i);
      end
    end
    push_data.item = in_ch.data;
    push_data.hit = hit;
    push_data.free = free;
    push_data.slot = hit ? hs : fs;
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else busy <= push;
  end
endmodule
`default_nettype wire

>>> rtl/peer_table_with_loss_tracking.sv
// Top level of the peer table with loss tracking.
// Depends on ptlt_pkg, the channel interfaces, front, queue and back parts.
//
//   channel   dir  payload
//   in_ch     in   mode, now_ms, peer_addr, peer_port, frame_* fields
//   out_ch    out  slot_status .. loss_percent
//   cfg       in   cfg_we, cfg_index, cfg_data (0 timeout, 1 heartbeat id)
//
// Tick, frame and raw items pass through the queue and the back part's S_IDLE
// and S_OUT states; the next item is accepted once the result is taken.
// A report adds S_SUM over every slot, S_MUL and S_DIV, where it waits for
// the one-bit-per-cycle 64-bit divider; with nothing received S_DIV is skipped.
// One item is in work at a time. Reset is synchronous and clears the table.
// A held result stalls the next item until it is taken.
`default_nettype none
module peer_table_with_loss_tracking
  import ptlt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  ptlt_item_if.sink        in_ch,
  ptlt_result_if.source    out_ch
);
  logic [15:0] silence_timeout_ms;
  logic [7:0]  heartbeat_msg_id;
  logic        push, pop, q_full, q_empty;
  cmd_t        push_data, pop_data;
  logic [PEER_SLOTS-1:0] active;
  logic [31:0] addr [PEER_SLOTS];
  logic [15:0] port [PEER_SLOTS];
  logic        back_idle;
  logic [3:0]  pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_timeout_ms <= TIMEOUT_RESET;
      heartbeat_msg_id <= HB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) silence_timeout_ms <= cfg_data;
      if (cfg_index == CFG_HB) heartbeat_msg_id <= cfg_data[7:0];
    end
  end

  ptlt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .back_idle (!pop && q_empty && !out_ch.valid && back_idle),
    .active    (active),
    .addr      (addr),
    .port      (port),
    .push      (push),
    .push_data (push_data)
  );

  // Counts items pushed but whose result is not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) pend <= 4'd0;
    else pend <= pend + {3'd0, push} - {3'd0, out_ch.valid && out_ch.ready};
  end
  assign back_idle = (pend == 4'd0);

  ptlt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  ptlt_back u_back (
    .clk                (clk),
    .rst                (rst),
    .silence_timeout_ms (silence_timeout_ms),
    .heartbeat_msg_id   (heartbeat_msg_id),
    .cmd_valid          (!q_empty),
    .cmd                (pop_data),
    .cmd_pop            (pop),
    .active_out         (active),
    .addr_out           (addr),
    .port_out           (port),
    .res                (out_ch)
  );
endmodule
`default_nettype wire
